@@ design/h264_fua_packetizer_defines.svh @@
// ----------------------------------------------------------------------------
// h264_fua_packetizer_defines
// assertion macros for the fu-a packetiser
// ----------------------------------------------------------------------------
`ifndef H264_FUA_PACKETIZER_DEFINES_SVH
`define H264_FUA_PACKETIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// ante implies cons in the same cycle
`define FUA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fua assertion failed");
// ante implies cons in the next cycle
`define FUA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fua assertion failed");
`else
`define FUA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FUA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/h264fua_pkg.sv @@
// ----------------------------------------------------------------------------
// h264fua_pkg
// shared constants and types of the fu-a packetiser
// ----------------------------------------------------------------------------
package h264fua_pkg;

    localparam int LenW  = 24;
    localparam int LimW  = 11;
    localparam int ByteW = 8;

    localparam logic [LenW-1:0] LenMax = '1;

    localparam logic [4:0]       FuAType   = 5'd28;
    localparam logic [ByteW-1:0] ShortMark = 8'h01;
    localparam int               NriShift  = 5;

    localparam logic [LimW-1:0] LimMin   = 11'd3;
    localparam logic [LimW-1:0] LimMax   = 11'd1500;
    localparam logic [LimW-1:0] LimReset = 11'd1400;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;

    // one queued word: a data byte, optionally preceded by fu indicator and header
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic [ByteW-1:0] fu_ind;
        logic [ByteW-1:0] fu_hdr;
        logic             has_hdr;
        logic             pend;
        logic             mark;
        logic             adv;
    } fua_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fua_qstat_t;

endpackage

@@ design/h264fua_front.sv @@
// ----------------------------------------------------------------------------
// h264fua_front
// accepts nal bytes, strips the start code and classifies each byte
// ----------------------------------------------------------------------------
module h264fua_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [h264fua_pkg::LimW-1:0]     max_len,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [h264fua_pkg::ByteW-1:0]    s_nal_byte,
    input  logic                             s_start_of_nal,
    input  logic [h264fua_pkg::LenW-1:0]     s_nal_length,
    input  h264fua_pkg::fua_qstat_t          q_stat,
    output logic                             q_push,
    output h264fua_pkg::fua_entry_t          q_entry
);
    import h264fua_pkg::*;

    logic [LenW-1:0]  byte_index_reg, byte_index_next;
    logic             lsc_reg, lsc_next;
    logic             frag_reg, frag_next;
    logic [ByteW-1:0] hdr_reg, hdr_next;
    logic [LimW-1:0]  chunk_reg, chunk_next;
    logic [LenW-1:0]  rem_reg, rem_next;
    logic             first_reg, first_next;

    logic             acc;
    logic             push;
    logic [LenW-1:0]  idx;
    logic             lsc, frag, first;
    logic [ByteW-1:0] hdr;
    logic [LimW-1:0]  chunk;
    logic [LenW-1:0]  rem;
    logic [LimW-1:0]  lim, csize;
    logic [LenW-1:0]  sc;
    logic             last, cend, skip;
    logic [LimW:0]    chunk_inc;

    assign s_ready = !q_stat.full;
    assign acc     = s_valid && s_ready;
    assign q_push  = acc && push;

    always_comb begin
        if (max_len < LimMin) begin
            lim = LimMin;
        end else if (max_len > LimMax) begin
            lim = LimMax;
        end else begin
            lim = max_len;
        end
        csize = lim - LimW'(2);
    end

    always_comb begin
        // a new unit starts from the reset state
        idx   = s_start_of_nal ? '0 : byte_index_reg;
        lsc   = s_start_of_nal ? 1'b0 : lsc_reg;
        frag  = s_start_of_nal ? 1'b0 : frag_reg;
        hdr   = s_start_of_nal ? '0 : hdr_reg;
        chunk = s_start_of_nal ? '0 : chunk_reg;
        rem   = s_start_of_nal ? '0 : rem_reg;
        first = s_start_of_nal ? 1'b1 : first_reg;

        byte_index_next = (idx != LenMax) ? idx + LenW'(1) : idx;
        lsc_next   = lsc;
        frag_next  = frag;
        hdr_next   = hdr;
        chunk_next = chunk;
        rem_next   = rem;
        first_next = first;

        push      = 1'b0;
        sc        = '0;
        last      = 1'b0;
        cend      = 1'b0;
        skip      = 1'b0;
        chunk_inc = {1'b0, chunk} + (LimW+1)'(1);
        q_entry   = '0;
        q_entry.data = s_nal_byte;
        q_entry.adv  = first;

        if (idx < LenW'(2)) begin
            // leading zeros of the start code
        end else if (idx == LenW'(2) || (idx == LenW'(3) && lsc)) begin
            lsc_next = (idx == LenW'(2)) ? (s_nal_byte != ShortMark) : lsc;
            if (!(idx == LenW'(2) && lsc_next)) begin
                sc         = lsc_next ? LenW'(4) : LenW'(3);
                rem_next   = (s_nal_length > sc) ? s_nal_length - sc : '0;
                frag_next  = rem_next > LenW'(lim);
                chunk_next = '0;
            end
        end else if (rem != '0) begin
            last = (rem == LenW'(1));
            if (idx == (lsc ? LenW'(4) : LenW'(3))) begin
                hdr_next = s_nal_byte;
                skip     = frag;   // nal header dropped in fragment mode
            end
            if (!skip && !frag) begin
                push         = 1'b1;
                q_entry.pend = last;
                q_entry.mark = last;
                if (last) begin
                    first_next = 1'b0;
                end
            end else if (!skip) begin
                push            = 1'b1;
                cend            = last || (chunk_inc >= {1'b0, csize});
                q_entry.has_hdr = (chunk == '0);
                q_entry.fu_ind  = {hdr_next[ByteW-1:NriShift], FuAType};
                q_entry.fu_hdr  = {first, (rem <= LenW'(csize)), 1'b0,
                                   hdr_next[NriShift-1:0]};
                q_entry.pend    = cend;
                q_entry.mark    = last;
                if (cend) begin
                    chunk_next = '0;
                    first_next = 1'b0;
                end else begin
                    chunk_next = chunk_inc[LimW-1:0];
                end
            end
            rem_next = rem - LenW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            lsc_reg        <= 1'b0;
            frag_reg       <= 1'b0;
            hdr_reg        <= '0;
            chunk_reg      <= '0;
            rem_reg        <= '0;
            first_reg      <= 1'b1;
        end else if (acc) begin
            byte_index_reg <= byte_index_next;
            lsc_reg        <= lsc_next;
            frag_reg       <= frag_next;
            hdr_reg        <= hdr_next;
            chunk_reg      <= chunk_next;
            rem_reg        <= rem_next;
            first_reg      <= first_next;
        end
    end

endmodule

@@ design/h264fua_fifo.sv @@
// ----------------------------------------------------------------------------
// h264fua_fifo
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module h264fua_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  h264fua_pkg::fua_entry_t wr_entry,
    input  logic                    pop,
    output h264fua_pkg::fua_entry_t head,
    output h264fua_pkg::fua_qstat_t stat
);
    import h264fua_pkg::*;

    fua_entry_t        slot_reg [FifoDepth];
    logic [FifoAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FifoAw:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == (FifoAw+1)'(FifoDepth));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (FifoAw+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (FifoAw+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FifoAw'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FifoAw'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/h264fua_back.sv @@
// ----------------------------------------------------------------------------
// h264fua_back
// expands queued words into payload bytes behind an output register
// ----------------------------------------------------------------------------
module h264fua_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  h264fua_pkg::fua_entry_t       q_head,
    input  h264fua_pkg::fua_qstat_t       q_stat,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [h264fua_pkg::ByteW-1:0] m_payload_byte,
    output logic                          m_packet_end,
    output logic                          m_marker,
    output logic                          m_advance_timestamp,
    output logic                          m_last_of_input
);
    import h264fua_pkg::*;

    localparam logic [1:0] PhInd  = 2'd0;
    localparam logic [1:0] PhHdr  = 2'd1;
    localparam logic [1:0] PhData = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic             m_valid_reg;
    logic [ByteW-1:0] byte_reg, byte_next;
    logic             pend_reg, pend_next;
    logic             mark_reg, mark_next;
    logic             adv_reg;
    logic             last_reg, last_next;
    logic             load, take;

    assign load  = !q_stat.empty && (!m_valid_reg || m_ready);
    assign q_pop = load && take;

    always_comb begin
        byte_next  = q_head.data;
        pend_next  = q_head.pend;
        mark_next  = q_head.mark;
        last_next  = 1'b1;
        phase_next = PhInd;
        take       = 1'b1;
        case (phase_reg)
            PhInd: begin
                if (q_head.has_hdr) begin
                    byte_next  = q_head.fu_ind;
                    pend_next  = 1'b0;
                    mark_next  = 1'b0;
                    last_next  = 1'b0;
                    phase_next = PhHdr;
                    take       = 1'b0;
                end
            end
            PhHdr: begin
                byte_next  = q_head.fu_hdr;
                pend_next  = 1'b0;
                mark_next  = 1'b0;
                last_next  = 1'b0;
                phase_next = PhData;
                take       = 1'b0;
            end
            PhData: begin
                phase_next = PhInd;
            end
            default: begin
                phase_next = PhInd;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= PhInd;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            phase_reg   <= phase_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            pend_reg <= pend_next;
            mark_reg <= mark_next;
            adv_reg  <= q_head.adv;
            last_reg <= last_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_payload_byte      = byte_reg;
    assign m_packet_end        = pend_reg;
    assign m_marker            = mark_reg;
    assign m_advance_timestamp = adv_reg;
    assign m_last_of_input     = last_reg;

endmodule

@@ design/h264_fua_packetizer.sv @@
// ----------------------------------------------------------------------------
// h264_fua_packetizer
// rtp payload builder for h.264 nal units: single packets and fu-a fragments
// ----------------------------------------------------------------------------
//  channel   direction  word
//  s_*       in         one annex b byte, start flag, unit length
//  m_*       out        one payload byte with packet end, marker, timestamp flags
//  cfg_*     in         max_packet_length (11 bit, reset 1400)
//
//  one input word is taken per cycle while the four-word queue has room
//  each input word yields zero to three output words, one per cycle while
//  the output is not stalled; fu indicator and header precede the data byte
//  input and output stall independently, the queue absorbs header bubbles
//  synchronous active-low reset; limit register resets to 1400
// ----------------------------------------------------------------------------
`include "h264_fua_packetizer_defines.svh"

module h264_fua_packetizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [h264fua_pkg::LimW-1:0]  cfg_max_packet_length,
    // nal byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [h264fua_pkg::ByteW-1:0] s_nal_byte,
    input  logic                          s_start_of_nal,
    input  logic [h264fua_pkg::LenW-1:0]  s_nal_length,
    // payload output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [h264fua_pkg::ByteW-1:0] m_payload_byte,
    output logic                          m_packet_end,
    output logic                          m_marker,
    output logic                          m_advance_timestamp,
    output logic                          m_last_of_input
);
    import h264fua_pkg::*;

    // packet size limit, clamped inside the front end
    logic [LimW-1:0] max_len_reg;

    // queue interface
    fua_entry_t q_entry, q_head;
    fua_qstat_t q_stat;
    logic       q_push, q_pop;

    // the register can always be written
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LimReset;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_max_packet_length;
        end
    end

    // front: start code strip, fragmentation decisions
    h264fua_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_len        (max_len_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_nal_byte     (s_nal_byte),
        .s_start_of_nal (s_start_of_nal),
        .s_nal_length   (s_nal_length),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    // decoupling queue
    h264fua_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_entry),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // back: header insertion and output register
    h264fua_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_head              (q_head),
        .q_stat              (q_stat),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_payload_byte      (m_payload_byte),
        .m_packet_end        (m_packet_end),
        .m_marker            (m_marker),
        .m_advance_timestamp (m_advance_timestamp),
        .m_last_of_input     (m_last_of_input)
    );

    // marker only ever rides on the end of a packet
    `FUA_ASSERT_IMPL(a_marker_end, aclk, aresetn, m_valid && m_marker, m_packet_end)
    // packet ends only on a data byte, which closes its input word
    `FUA_ASSERT_IMPL(a_end_last, aclk, aresetn, m_valid && m_packet_end, m_last_of_input)
    // queue status is never both full and empty
    `FUA_ASSERT_IMPL(a_q_stat, aclk, aresetn, q_stat.full, !q_stat.empty)
    // a pop always hands over a word the back end has registered
    `FUA_ASSERT_NEXT(a_pop_valid, aclk, aresetn, q_pop, m_valid && m_last_of_input)

endmodule
